/* hdl/nclip_pkg.sv */
// Shared types and constants of the near-plane clip and projection unit.
package nclip_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DELTA_W     = 17;
  localparam int unsigned COLOR_W     = 4;
  localparam int unsigned W_W         = 24;
  localparam int unsigned NUM_W       = 66;
  localparam int unsigned MAG_W       = 65;
  localparam int unsigned Q_BITS      = 17;
  localparam int unsigned D_SHIFT     = 22;
  localparam int unsigned CENTER_SHIFT = 28;
  localparam int unsigned OFF_SHIFT   = 14;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic signed [COORD_W-1:0] NEAR_Z   = 16'sd204;
  localparam logic signed [DELTA_W-1:0] CLIP_Z   = 17'sd205;
  localparam logic signed [NUM_W-1:0]   FOCAL_Q8 = 66'sd14848;
  localparam logic signed [COORD_W-1:0] UNIT_Q14 = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X  = 3'd0,
    CFG_OFFSET_Y  = 3'd1,
    CFG_ROLL_EN   = 3'd2,
    CFG_ROLL_COS  = 3'd3,
    CFG_ROLL_SIN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic                      roll_en;
    logic signed [COORD_W-1:0] cos_q14;
    logic signed [COORD_W-1:0] sin_q14;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
    logic signed [DELTA_W-1:0] span;
    logic                      near;
  } pt_t;

  typedef struct packed {
    pt_t                s;
    pt_t                e;
    logic [COLOR_W-1:0] color;
  } seg_t;

endpackage

/* hdl/near_clip_perspective_line_unit.sv */
// Top level of the near-plane clip and perspective projection unit for line segments.
//
//  channel | ports                | direction | request
//  --------+----------------------+-----------+-------------------------------
//  in      | in_valid / in_ready  | input     | one segment, two endpoints, colour
//  out     | out_valid/out_ready  | output    | four screen coordinates, colour
//  cfg     | cfg_valid/cfg_ready  | input     | register index and write data
//
// One request per cycle sustained while the output is not stalled; from acceptance to out_valid a
// request passes the queue, six arithmetic stages, the 18-stage divider and the output register.
// Segments with both endpoints at or before the near plane are taken and dropped.
// Reset is synchronous; configuration resets to no offset and no roll.
// A stalled output freezes the back end; the queue keeps in_ready up until it fills.
module near_clip_perspective_line_unit #(
  parameter int unsigned QUEUE_DEPTH = nclip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_start_z,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_end_y,
  input  logic signed [nclip_pkg::COORD_W-1:0]   in_end_z,
  input  logic        [nclip_pkg::COLOR_W-1:0]   in_line_color,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [nclip_pkg::COORD_W-1:0]   out_start_screen_x,
  output logic signed [nclip_pkg::COORD_W-1:0]   out_start_screen_y,
  output logic signed [nclip_pkg::COORD_W-1:0]   out_end_screen_x,
  output logic signed [nclip_pkg::COORD_W-1:0]   out_end_screen_y,
  output logic        [nclip_pkg::COLOR_W-1:0]   out_color,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [nclip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [nclip_pkg::COORD_W-1:0]   cfg_data
);

  nclip_pkg::cfg_t cfg_r, cfg_nxt;
  nclip_pkg::seg_t push_seg, pop_seg;
  logic            push, push_ready, pop, pop_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (nclip_pkg::cfg_idx_t'(cfg_index))
        nclip_pkg::CFG_OFFSET_X: cfg_nxt.off_x    = $signed(cfg_data);
        nclip_pkg::CFG_OFFSET_Y: cfg_nxt.off_y    = $signed(cfg_data);
        nclip_pkg::CFG_ROLL_EN:  cfg_nxt.roll_en  = cfg_data[0];
        nclip_pkg::CFG_ROLL_COS: cfg_nxt.cos_q14  = $signed(cfg_data);
        nclip_pkg::CFG_ROLL_SIN: cfg_nxt.sin_q14  = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_x    <= '0;
      cfg_r.off_y    <= '0;
      cfg_r.roll_en  <= 1'b0;
      cfg_r.cos_q14  <= nclip_pkg::UNIT_Q14;
      cfg_r.sin_q14  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nclip_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_start_z    (in_start_z),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_end_z      (in_end_z),
    .in_line_color (in_line_color),
    .q_ready       (push_ready),
    .q_push        (push),
    .q_seg         (push_seg)
  );

  nclip_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_seg),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_seg)
  );

  nclip_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (pop_valid),
    .q_seg              (pop_seg),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_start_screen_x (out_start_screen_x),
    .out_start_screen_y (out_start_screen_y),
    .out_end_screen_x   (out_end_screen_x),
    .out_end_screen_y   (out_end_screen_y),
    .out_color          (out_color)
  );

endmodule

/* hdl/nclip_front.sv */
// Front end: accepts segments, classifies endpoints against the near plane, drops hidden ones.
module nclip_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_start_z,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_end_y,
  input  logic signed [nclip_pkg::COORD_W-1:0] in_end_z,
  input  logic        [nclip_pkg::COLOR_W-1:0] in_line_color,
  input  logic                                 q_ready,
  output logic                                 q_push,
  output nclip_pkg::seg_t                      q_seg
);

  logic s_near, e_near;

  assign s_near = in_start_z <= nclip_pkg::NEAR_Z;
  assign e_near = in_end_z <= nclip_pkg::NEAR_Z;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && !(s_near && e_near);

  always_comb begin
    q_seg.s.x    = in_start_x;
    q_seg.s.y    = in_start_y;
    q_seg.s.z    = in_start_z;
    q_seg.s.dx   = 17'(in_end_x) - 17'(in_start_x);
    q_seg.s.dy   = 17'(in_end_y) - 17'(in_start_y);
    q_seg.s.dz   = 17'(in_end_z) - 17'(in_start_z);
    q_seg.s.span = nclip_pkg::CLIP_Z - 17'(in_start_z);
    q_seg.s.near = s_near;
    q_seg.e.x    = in_end_x;
    q_seg.e.y    = in_end_y;
    q_seg.e.z    = in_end_z;
    q_seg.e.dx   = 17'(in_start_x) - 17'(in_end_x);
    q_seg.e.dy   = 17'(in_start_y) - 17'(in_end_y);
    q_seg.e.dz   = 17'(in_start_z) - 17'(in_end_z);
    q_seg.e.span = nclip_pkg::CLIP_Z - 17'(in_end_z);
    q_seg.e.near = e_near;
    q_seg.color  = in_line_color;
  end

endmodule

/* hdl/nclip_fifo.sv */
// Short request queue between the front end and the arithmetic back end.
module nclip_fifo #(
  parameter int unsigned DEPTH = nclip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nclip_pkg::seg_t push_data,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output nclip_pkg::seg_t pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nclip_pkg::seg_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = count_r < CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("request queue count beyond depth");
`endif

endmodule

/* hdl/nclip_div.sv */
// Pipelined restoring divider: screen magnitude over the scaled depth, one quotient bit a stage.
module nclip_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic [nclip_pkg::MAG_W-1:0]        mag_i,
  input  logic [nclip_pkg::W_W-1:0]          w_i,
  input  logic                               neg_i,
  output logic [nclip_pkg::Q_BITS-1:0]       q_o,
  output logic                               sat_o,
  output logic                               neg_o
);

  localparam int unsigned QB = nclip_pkg::Q_BITS;
  localparam int unsigned MW = nclip_pkg::MAG_W;

  logic [MW-1:0]                  rem_r [QB+1];
  logic [nclip_pkg::W_W-1:0]      w_r   [QB+1];
  logic [QB-1:0]                  q_r   [QB+1];
  logic                           sat_r [QB+1];
  logic                           neg_r [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag_i;
      w_r[0]   <= w_i;
      q_r[0]   <= '0;
      sat_r[0] <= mag_i >= (MW'(w_i) << (nclip_pkg::D_SHIFT + QB));
      neg_r[0] <= neg_i;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int unsigned B = QB - j;
    logic [MW-1:0] sh;
    logic          ge;

    assign sh = MW'(w_r[j-1]) << (nclip_pkg::D_SHIFT + B);
    assign ge = rem_r[j-1] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - sh : rem_r[j-1];
        q_r[j]   <= q_r[j-1] | (ge ? (QB'(1) << B) : '0);
        w_r[j]   <= w_r[j-1];
        sat_r[j] <= sat_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign q_o   = q_r[QB];
  assign sat_o = sat_r[QB];
  assign neg_o = neg_r[QB];

endmodule

/* hdl/nclip_back.sv */
// Back end: clip interpolation, rotation, projection numerator, division and output register.
module nclip_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  nclip_pkg::cfg_t                       cfg,
  input  logic                                  q_valid,
  input  nclip_pkg::seg_t                       q_seg,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [nclip_pkg::COORD_W-1:0]  out_start_screen_x,
  output logic signed [nclip_pkg::COORD_W-1:0]  out_start_screen_y,
  output logic signed [nclip_pkg::COORD_W-1:0]  out_end_screen_x,
  output logic signed [nclip_pkg::COORD_W-1:0]  out_end_screen_y,
  output logic        [nclip_pkg::COLOR_W-1:0]  out_color
);

  localparam int unsigned QB  = nclip_pkg::Q_BITS;
  localparam int unsigned NST = 6 + QB + 1;
  localparam int unsigned WW  = nclip_pkg::W_W;

  function automatic logic signed [15:0] clamp_q(input logic [QB-1:0] q,
                                                 input logic sat, input logic neg);
    logic signed [15:0] r;
    if (sat) begin
      r = neg ? 16'sh8000 : 16'sh7fff;
    end else if (neg) begin
      r = (q >= QB'(32768)) ? 16'sh8000 : -$signed(q[15:0]);
    end else begin
      r = (q >= QB'(32768)) ? 16'sh7fff : $signed(q[15:0]);
    end
    return r;
  endfunction

  logic                en;
  logic [NST-1:0]      v_r;
  logic [3:0]          col_r [NST];
  nclip_pkg::pt_t      pt [2];

  logic signed [32:0]  m1_r [2];
  logic signed [33:0]  m2_r [2];
  logic signed [32:0]  m3_r [2];
  logic signed [33:0]  m4_r [2];
  logic [WW-1:0]       wc_r [2];
  logic signed [15:0]  x1_r [2], y1_r [2], z1_r [2];
  logic                n1_r [2];

  logic signed [34:0]  x2_r [2], y2_r [2];
  logic [WW-1:0]       w2_r [2];

  logic signed [15:0]  cc, ss;
  logic signed [50:0]  xc_r [2], ys_r [2], xs_r [2], yc_r [2];
  logic signed [40:0]  ox3_r [2], oy3_r [2];
  logic [WW-1:0]       w3_r [2];

  logic signed [51:0]  rx4_r [2], ry4_r [2];
  logic signed [40:0]  ox4_r [2], oy4_r [2];
  logic [WW-1:0]       w4_r [2];

  logic signed [65:0]  nx5_r [2], ny5_r [2];
  logic [WW-1:0]       w5_r [2];

  logic [64:0]         mx6_r [2], my6_r [2];
  logic                gx6_r [2], gy6_r [2];
  logic [WW-1:0]       w6_r [2];

  logic [QB-1:0]       dq [4];
  logic                dsat [4], dneg [4];

  logic                out_valid_r;
  logic signed [15:0]  osx_r, osy_r, oex_r, oey_r;
  logic [3:0]          ocol_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;
  assign pt[0] = q_seg.s;
  assign pt[1] = q_seg.e;
  assign cc    = cfg.roll_en ? cfg.cos_q14 : nclip_pkg::UNIT_Q14;
  assign ss    = cfg.roll_en ? cfg.sin_q14 : 16'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r[0] <= q_seg.color;
      for (int i = 1; i < NST; i++) begin
        col_r[i] <= col_r[i-1];
      end
      for (int k = 0; k < 2; k++) begin
        m1_r[k]  <= pt[k].x * pt[k].dz;
        m2_r[k]  <= pt[k].dx * pt[k].span;
        m3_r[k]  <= pt[k].y * pt[k].dz;
        m4_r[k]  <= pt[k].dy * pt[k].span;
        wc_r[k]  <= WW'(pt[k].dz[15:0]) * WW'(205);
        x1_r[k]  <= pt[k].x;
        y1_r[k]  <= pt[k].y;
        z1_r[k]  <= pt[k].z;
        n1_r[k]  <= pt[k].near;

        x2_r[k]  <= n1_r[k] ? 35'(m1_r[k]) + 35'(m2_r[k]) : 35'(x1_r[k]);
        y2_r[k]  <= n1_r[k] ? 35'(m3_r[k]) + 35'(m4_r[k]) : 35'(y1_r[k]);
        w2_r[k]  <= n1_r[k] ? wc_r[k] : WW'(z1_r[k][14:0]);

        xc_r[k]  <= x2_r[k] * cc;
        ys_r[k]  <= y2_r[k] * ss;
        xs_r[k]  <= x2_r[k] * ss;
        yc_r[k]  <= y2_r[k] * cc;
        ox3_r[k] <= cfg.off_x * $signed({1'b0, w2_r[k]});
        oy3_r[k] <= cfg.off_y * $signed({1'b0, w2_r[k]});
        w3_r[k]  <= w2_r[k];

        rx4_r[k] <= 52'(xc_r[k]) + 52'(ys_r[k]);
        ry4_r[k] <= 52'(xs_r[k]) - 52'(yc_r[k]);
        ox4_r[k] <= ox3_r[k];
        oy4_r[k] <= oy3_r[k];
        w4_r[k]  <= w3_r[k];

        nx5_r[k] <= (66'($signed({1'b0, w4_r[k]})) <<< nclip_pkg::CENTER_SHIFT)
                    + 66'(rx4_r[k]) * nclip_pkg::FOCAL_Q8
                    + (66'(ox4_r[k]) <<< nclip_pkg::OFF_SHIFT);
        ny5_r[k] <= (66'($signed({1'b0, w4_r[k]})) <<< nclip_pkg::CENTER_SHIFT)
                    + 66'(ry4_r[k]) * nclip_pkg::FOCAL_Q8
                    + (66'(oy4_r[k]) <<< nclip_pkg::OFF_SHIFT);
        w5_r[k]  <= w4_r[k];

        gx6_r[k] <= nx5_r[k][65];
        gy6_r[k] <= ny5_r[k][65];
        mx6_r[k] <= nx5_r[k][65] ? 65'(-nx5_r[k]) : 65'(nx5_r[k]);
        my6_r[k] <= ny5_r[k][65] ? 65'(-ny5_r[k]) : 65'(ny5_r[k]);
        w6_r[k]  <= w5_r[k];
      end
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_lane
    nclip_div u_div_x (
      .clk   (clk),
      .en    (en),
      .mag_i (mx6_r[k]),
      .w_i   (w6_r[k]),
      .neg_i (gx6_r[k]),
      .q_o   (dq[2*k]),
      .sat_o (dsat[2*k]),
      .neg_o (dneg[2*k])
    );
    nclip_div u_div_y (
      .clk   (clk),
      .en    (en),
      .mag_i (my6_r[k]),
      .w_i   (w6_r[k]),
      .neg_i (gy6_r[k]),
      .q_o   (dq[2*k+1]),
      .sat_o (dsat[2*k+1]),
      .neg_o (dneg[2*k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      osx_r  <= clamp_q(dq[0], dsat[0], dneg[0]);
      osy_r  <= clamp_q(dq[1], dsat[1], dneg[1]);
      oex_r  <= clamp_q(dq[2], dsat[2], dneg[2]);
      oey_r  <= clamp_q(dq[3], dsat[3], dneg[3]);
      ocol_r <= col_r[NST-1];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_screen_x = osx_r;
  assign out_start_screen_y = osy_r;
  assign out_end_screen_x   = oex_r;
  assign out_end_screen_y   = oey_r;
  assign out_color          = ocol_r;

`ifndef SYNTHESIS
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline advanced while output stalled");
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[NST-1]) |=> out_valid_r)
    else $error("finished request lost before output register");
  a_depth_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (w2_r[0] != '0 && w2_r[1] != '0))
    else $error("zero divisor depth in flight");
`endif

endmodule

/* dv/near_clip_perspective_line_unit_tb.sv */
// Testbench for the near-plane clip and perspective projection unit, with its own line predictor.
`timescale 1ns / 100ps

module near_clip_perspective_line_unit_tb;

  localparam logic [nclip_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [3:0]         col;
  } screen_line_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_start_x, in_start_y, in_start_z;
  logic signed [15:0] in_end_x, in_end_y, in_end_z;
  logic [3:0] in_line_color;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_start_screen_x, out_start_screen_y;
  logic signed [15:0] out_end_screen_x, out_end_screen_y;
  logic [3:0] out_color;
  logic cfg_valid;
  logic cfg_ready;
  logic [nclip_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  logic signed [15:0] view_off_x, view_off_y, cos_q14, sin_q14;
  logic roll_on;

  screen_line_t expected_lines[$];
  int mismatch_count;
  int burst_left;
  int stall_mode;

  near_clip_perspective_line_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [15:0] screen_coord(longint w, longint rot, longint off);
    longint den, num, q;
    den = w * 64'sd4194304;
    num = 64'sd64 * den + 64'sd14848 * rot + off * w * 64'sd16384;
    q = num / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void homog(longint px, py, pz, qx, qy, qz, bit near_pt,
                                output longint hx, hy, hw);
    longint dz, span;
    if (!near_pt) begin
      hx = px; hy = py; hw = pz;
    end else begin
      dz = qz - pz;
      span = 205 - pz;
      hx = px * dz + (qx - px) * span;
      hy = py * dz + (qy - py) * span;
      hw = 205 * dz;
    end
  endfunction

  // Return 1 and fill the line when the segment survives the near plane.
  function automatic bit predict_line(logic signed [15:0] ax, ay, az, bx, by, bz,
                                      logic [3:0] col, output screen_line_t ln);
    longint xa, ya, wa, xb, yb, wb, c, s;
    bit a_near, b_near;
    a_near = az <= 16'sd204;
    b_near = bz <= 16'sd204;
    if (a_near && b_near) return 0;
    homog(longint'(ax), longint'(ay), longint'(az), longint'(bx), longint'(by),
          longint'(bz), a_near, xa, ya, wa);
    homog(longint'(bx), longint'(by), longint'(bz), longint'(ax), longint'(ay),
          longint'(az), b_near, xb, yb, wb);
    c = 16384;
    s = 0;
    if (roll_on) begin
      c = longint'(cos_q14);
      s = longint'(sin_q14);
    end
    ln.sx = screen_coord(wa, xa * c + ya * s, longint'(view_off_x));
    ln.sy = screen_coord(wa, xa * s - ya * c, longint'(view_off_y));
    ln.ex = screen_coord(wb, xb * c + yb * s, longint'(view_off_x));
    ln.ey = screen_coord(wb, xb * s - yb * c, longint'(view_off_y));
    ln.col = col;
    return 1;
  endfunction

  // Receiver stall pattern, changing mode every so often.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(negedge clk) begin
    screen_line_t exp_ln;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected line %0d %0d %0d %0d col %0d", out_start_screen_x,
                   out_start_screen_y, out_end_screen_x, out_end_screen_y, out_color);
      end else begin
        exp_ln = expected_lines.pop_front();
        if (out_start_screen_x !== exp_ln.sx || out_start_screen_y !== exp_ln.sy ||
            out_end_screen_x !== exp_ln.ex || out_end_screen_y !== exp_ln.ey ||
            out_color !== exp_ln.col) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("line mismatch exp %0d %0d %0d %0d col %0d got %0d %0d %0d %0d col %0d",
                     exp_ln.sx, exp_ln.sy, exp_ln.ex, exp_ln.ey, exp_ln.col,
                     out_start_screen_x, out_start_screen_y, out_end_screen_x,
                     out_end_screen_y, out_color);
        end
      end
    end
  end

  task automatic send_segment(int ax, ay, az, bx, by, bz, int col);
    screen_line_t ln;
    bit seen;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    if (predict_line(16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz), 4'(col), ln))
      expected_lines.push_back(ln);
    in_valid <= 1'b1;
    in_start_x <= 16'(ax);
    in_start_y <= 16'(ay);
    in_start_z <= 16'(az);
    in_end_x <= 16'(bx);
    in_end_y <= 16'(by);
    in_end_z <= 16'(bz);
    in_line_color <= 4'(col);
    do begin
      @(negedge clk);
      seen = in_ready;
      @(posedge clk);
    end while (!seen);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [nclip_pkg::CFG_IDX_W-1:0] idx, int value);
    bit seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      nclip_pkg::CFG_OFFSET_X: view_off_x = 16'(value);
      nclip_pkg::CFG_OFFSET_Y: view_off_y = 16'(value);
      nclip_pkg::CFG_ROLL_EN:  roll_on = value[0];
      nclip_pkg::CFG_ROLL_COS: cos_q14 = 16'(value);
      nclip_pkg::CFG_ROLL_SIN: sin_q14 = 16'(value);
      default: ;
    endcase
  endtask

  task automatic set_view(int ox, oy, en, c, s);
    write_reg(nclip_pkg::CFG_OFFSET_X, ox);
    write_reg(nclip_pkg::CFG_OFFSET_Y, oy);
    write_reg(nclip_pkg::CFG_ROLL_EN, en);
    write_reg(nclip_pkg::CFG_ROLL_COS, c);
    write_reg(nclip_pkg::CFG_ROLL_SIN, s);
  endtask

  function automatic int far_z();
    return $urandom_range(0, 3) == 0 ? $urandom_range(205, 32767) : $urandom_range(205, 2000);
  endfunction

  function automatic int near_z();
    return int'($urandom_range(0, 32972)) - 32768;
  endfunction

  task automatic send_random_segment();
    int az, bz;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin az = far_z(); bz = far_z(); end
      6: begin az = near_z(); bz = far_z(); end
      7: begin az = far_z(); bz = near_z(); end
      8: begin az = near_z(); bz = near_z(); end
      default: begin az = $urandom_range(0, 65535); bz = $urandom_range(0, 65535); end
    endcase
    send_segment($urandom_range(0, 65535), $urandom_range(0, 65535), az,
                 $urandom_range(0, 65535), $urandom_range(0, 65535), bz,
                 $urandom_range(0, 15));
  endtask

  task automatic test_directed_edges();
    send_segment(0, 0, 256, 0, 0, 512, 0);
    send_segment(32767, -32768, 205, -32768, 32767, 205, 15);
    send_segment(-32768, 32767, 32767, 32767, -32768, 32767, 5);
    send_segment(100, 200, 204, 300, -400, 205, 1);
    send_segment(100, 200, 205, 300, -400, 204, 2);
    send_segment(32767, 32767, -32768, -32768, -32768, 32767, 3);
    send_segment(-32768, 32767, 32767, 32767, -32768, -32768, 4);
    send_segment(0, 0, 204, 0, 0, 204, 6);
    send_segment(5, 5, -32768, 7, 7, 0, 7);
    send_segment(256, 256, 0, 512, -512, 1024, 8);
    send_segment(1, -1, 206, -1, 1, 32767, 9);
    wait_idle();
  endtask

  task automatic test_offsets();
    set_view(32767, -32768, 0, 16384, 0);
    send_segment(1000, -1000, 300, -2000, 2000, 800, 10);
    send_segment(0, 0, 205, 100, 100, 204, 11);
    wait_idle();
    set_view(-32768, 32767, 0, 16384, 0);
    send_segment(1000, -1000, 300, -2000, 2000, 800, 12);
    send_segment(-32768, -32768, 205, 32767, 32767, 32767, 13);
    wait_idle();
  endtask

  task automatic test_roll();
    set_view(0, 0, 1, 0, 16384);
    send_segment(1000, 500, 400, -700, 300, 900, 1);
    wait_idle();
    set_view(0, 0, 1, -16384, -16384);
    send_segment(1000, 500, 400, -700, 300, 900, 2);
    send_segment(32767, 32767, 205, -32768, -32768, 204, 3);
    wait_idle();
    set_view(0, 0, 1, -32768, 32767);
    send_segment(1000, 500, 400, -700, 300, 900, 4);
    wait_idle();
    write_reg(nclip_pkg::CFG_ROLL_EN, 0);
    write_reg(CFG_SPARE_IDX, 16'h1234);
    send_segment(1000, 500, 400, -700, 300, 900, 5);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_view(0, 0, 0, 16384, 0);
        1: set_view($urandom_range(0, 65535), $urandom_range(0, 65535), 0,
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        2: set_view(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                    1, int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 32768)) - 16384);
        default: set_view($urandom_range(0, 65535), $urandom_range(0, 65535), 1,
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      repeat (100) send_random_segment();
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z} = '0;
    in_line_color = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    view_off_x = 0;
    view_off_y = 0;
    roll_on = 1'b0;
    cos_q14 = 16384;
    sin_q14 = 0;
    mismatch_count = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_offsets();
    test_roll();
    test_random_traffic();
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* near_clip_perspective_line_unit.f */
hdl/nclip_pkg.sv
hdl/nclip_front.sv
hdl/nclip_fifo.sv
hdl/nclip_div.sv
hdl/nclip_back.sv
hdl/near_clip_perspective_line_unit.sv
dv/near_clip_perspective_line_unit_tb.sv
